>>> src/tcw_pkg.sv
`timescale 1ns / 1ps

package tcw_pkg;

    // Field widths of one command and one result
    localparam int KIND_W  = 2;
    localparam int CODE_W  = 8;
    localparam int ROW_W   = 5;
    localparam int COL_W   = 7;

    // Configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 8;

    typedef logic [KIND_W-1:0]    t_kind;
    typedef logic [CODE_W-1:0]    t_code;
    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;

    // Command kinds
    localparam t_kind KIND_PUT   = 2'd0;
    localparam t_kind KIND_CLEAR = 2'd1;
    localparam t_kind KIND_READ  = 2'd2;

    // Register indexes
    localparam t_cfg_idx REG_NEWLINE   = 2'd0;
    localparam t_cfg_idx REG_RETURN    = 2'd1;
    localparam t_cfg_idx REG_BACKSPACE = 2'd2;
    localparam t_cfg_idx REG_BS_IGNORE = 2'd3;

    // Register reset values
    localparam t_code NEWLINE_RST   = 8'd10;
    localparam t_code RETURN_RST    = 8'd13;
    localparam t_code BACKSPACE_RST = 8'd8;

endpackage

>>> src/text_console_writer_core.sv
`timescale 1ns / 1ps

// Character-cell text console: a ROWS x COLS byte store in one synchronous RAM plus a
// cursor. A command is taken when start is high and busy is low; every command gives
// exactly one result, shown for one cycle with o_valid high, and the receiver cannot
// stall it. Put commands that do not scroll, read and unused-kind commands leave busy
// low and give their result in the cycle after the command is taken, so one command
// per cycle is sustained for them. A clear command holds busy while it blanks each
// cell (one RAM write per cell) and a put that scrolls holds it while it copies the
// cells up a row (one cell copied per cycle through the single RAM read and write
// port, then the last row blanked); the result comes in the cycle busy falls. After
// reset the RAM is cleared with busy high; register writes are taken at any time.
module text_console_writer_core
    import tcw_pkg::*;
#(
    parameter int COLS = 80,
    parameter int ROWS = 30
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  start,
    output logic                  busy,
    input  logic [KIND_W-1:0]     i_kind,
    input  logic [CODE_W-1:0]     i_char_code,
    input  logic [ROW_W-1:0]      i_read_row,
    input  logic [COL_W-1:0]      i_read_col,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output logic                  o_valid,
    output logic [ROW_W-1:0]      o_cursor_row,
    output logic [COL_W-1:0]      o_cursor_col,
    output logic [CODE_W-1:0]     o_cell_value,
    output logic                  o_scrolled
);

    localparam int CELLS = ROWS * COLS;
    localparam int AW    = $clog2(CELLS);
    localparam int RW    = $clog2(ROWS);
    localparam int CW    = $clog2(COLS);

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_SCROLL = 2'd1;
    localparam logic [1:0] S_FILL   = 2'd2;

    logic [1:0]        r_state;
    logic [AW-1:0]     r_cnt;
    logic              r_report;
    logic [RW-1:0]     r_row;
    logic [CW-1:0]     r_col;
    logic              r_valid;
    logic              r_scrolled;
    logic              r_cell_ok;
    logic [CODE_W-1:0] r_rd_q;

    logic [CODE_W-1:0] r_nl_code;
    logic [CODE_W-1:0] r_ret_code;
    logic [CODE_W-1:0] r_bs_code;
    logic              r_bs_ignore;

    logic [CODE_W-1:0] r_mem [CELLS];

    logic              accept;
    logic [CW:0]       put_col;
    logic [RW:0]       put_row;
    logic              put_we;
    logic [CW-1:0]     put_wcol;
    logic [CODE_W-1:0] put_wdata;
    logic              put_scroll;
    logic              rd_in_range;

    logic              mem_we;
    logic [AW-1:0]     mem_waddr;
    logic [CODE_W-1:0] mem_wdata;
    logic              mem_re;
    logic [AW-1:0]     mem_raddr;

    assign busy   = (r_state != S_IDLE);
    assign accept = start && !busy;

    // Cursor move and cell write of a put command
    always_comb begin
        put_col    = {1'b0, r_col};
        put_row    = {1'b0, r_row};
        put_we     = 1'b0;
        put_wcol   = r_col;
        put_wdata  = '0;
        put_scroll = 1'b0;
        if (i_char_code == r_ret_code) begin
            put_col = {1'b0, r_col};
        end else if (i_char_code == r_bs_code) begin
            if (!r_bs_ignore && r_col != '0) begin
                put_col  = {1'b0, r_col} - (CW+1)'(1);
                put_we   = 1'b1;
                put_wcol = r_col - CW'(1);
            end
        end else if (i_char_code == r_nl_code) begin
            put_col = '0;
            put_row = {1'b0, r_row} + (RW+1)'(1);
        end else begin
            put_we    = 1'b1;
            put_wdata = i_char_code;
            put_col   = {1'b0, r_col} + (CW+1)'(1);
        end
        if (put_col >= (CW+1)'(COLS)) begin
            put_col = '0;
            put_row = put_row + (RW+1)'(1);
        end
        if (put_row >= (RW+1)'(ROWS)) begin
            put_row    = (RW+1)'(ROWS - 1);
            put_scroll = 1'b1;
        end
    end

    assign rd_in_range = (32'(i_read_row) < ROWS) && (32'(i_read_col) < COLS);

    // RAM port control
    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = r_cnt;
        mem_wdata = '0;
        mem_re    = 1'b0;
        mem_raddr = AW'(AW'(i_read_row) * AW'(COLS)) + AW'(i_read_col);
        case (r_state)
            S_IDLE: begin
                if (accept && i_kind == KIND_PUT && put_we) begin
                    mem_we    = 1'b1;
                    mem_waddr = AW'(AW'(r_row) * AW'(COLS)) + AW'(put_wcol);
                    mem_wdata = put_wdata;
                end
                mem_re = accept && i_kind == KIND_READ && rd_in_range;
            end
            S_SCROLL: begin
                // read one row ahead, write the cell read in the previous cycle
                mem_re    = (r_cnt < AW'(CELLS - COLS));
                mem_raddr = r_cnt + AW'(COLS);
                mem_we    = (r_cnt != '0);
                mem_waddr = r_cnt - AW'(1);
                mem_wdata = r_rd_q;
            end
            S_FILL: begin
                mem_we    = 1'b1;
                mem_waddr = r_cnt;
                mem_wdata = '0;
            end
            default: begin
                mem_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re) begin
            r_rd_q <= r_mem[mem_raddr];
        end
    end

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_nl_code   <= NEWLINE_RST;
            r_ret_code  <= RETURN_RST;
            r_bs_code   <= BACKSPACE_RST;
            r_bs_ignore <= 1'b0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_NEWLINE:   r_nl_code   <= i_cfg_data;
                REG_RETURN:    r_ret_code  <= i_cfg_data;
                REG_BACKSPACE: r_bs_code   <= i_cfg_data;
                REG_BS_IGNORE: r_bs_ignore <= i_cfg_data[0];
                default:       r_bs_ignore <= r_bs_ignore;
            endcase
        end
    end

    // Sequencer and cursor
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_FILL;
            r_cnt      <= '0;
            r_report   <= 1'b0;
            r_row      <= '0;
            r_col      <= '0;
            r_valid    <= 1'b0;
            r_scrolled <= 1'b0;
            r_cell_ok  <= 1'b0;
        end else begin
            r_valid <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_scrolled <= 1'b0;
                        r_cell_ok  <= 1'b0;
                        r_report   <= 1'b1;
                        case (i_kind)
                            KIND_PUT: begin
                                r_row      <= RW'(put_row);
                                r_col      <= CW'(put_col);
                                r_scrolled <= put_scroll;
                                if (put_scroll) begin
                                    r_state <= S_SCROLL;
                                    r_cnt   <= '0;
                                end else begin
                                    r_valid <= 1'b1;
                                end
                            end
                            KIND_CLEAR: begin
                                r_row   <= '0;
                                r_col   <= '0;
                                r_state <= S_FILL;
                                r_cnt   <= '0;
                            end
                            KIND_READ: begin
                                r_cell_ok <= rd_in_range;
                                r_valid   <= 1'b1;
                            end
                            default: begin
                                r_valid <= 1'b1;
                            end
                        endcase
                    end
                end
                S_SCROLL: begin
                    // hold the counter at the first cell of the last row for the blank
                    if (r_cnt == AW'(CELLS - COLS)) begin
                        r_state <= S_FILL;
                    end else begin
                        r_cnt <= r_cnt + AW'(1);
                    end
                end
                S_FILL: begin
                    if (r_cnt == AW'(CELLS - 1)) begin
                        r_state <= S_IDLE;
                        r_valid <= r_report;
                    end else begin
                        r_cnt <= r_cnt + AW'(1);
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_valid      = r_valid;
    assign o_cursor_row = ROW_W'(32'(r_row));
    assign o_cursor_col = COL_W'(32'(r_col));
    assign o_cell_value = r_cell_ok ? r_rd_q : '0;
    assign o_scrolled   = r_scrolled;

endmodule
